// File: rtl/ordered_key_set_core_macros.svh
// Assertion macros shared by the ordered key set RTL.
`ifndef ORDERED_KEY_SET_CORE_MACROS_SVH
`define ORDERED_KEY_SET_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define OKC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ordered key set assertion failed");
// Check that a condition implies another in the following cycle.
`define OKC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered key set assertion failed");
`else
`define OKC_ASSERT(label, prop)
`define OKC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/okc_pkg.sv
// Shared constants, codes and types of the ordered key set.
package okc_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_EXISTS = 3'd2;
  localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PREV   = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic ins_shift;
    logic del_shift;
    logic sel_next;
    logic sel_prev;
  } cell_ctrl_t;

endpackage

// File: rtl/okc_cell.sv
// One slot of the sorted key chain: holds a key, compares it and shifts it.
module okc_cell
  import okc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    probe_en,
  input  logic signed [KEY_W-1:0] probe,
  input  logic                    occ,
  input  cell_ctrl_t              ctrl,
  input  logic signed [KEY_W-1:0] q,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic                    left_lt,
  input  logic                    left_gt,
  input  logic                    right_lt,
  output logic                    lt,
  output logic                    gt,
  output logic                    eq,
  output logic signed [KEY_W-1:0] key,
  output logic                    hit,
  output logic [KEY_W-1:0]        hit_value
);

  // Latch the comparison against the incoming request key
  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      gt <= 1'b0;
      eq <= 1'b0;
    end else if (probe_en) begin
      lt <= occ && (key < probe);
      gt <= occ && (key > probe);
      eq <= occ && (key == probe);
    end
  end

  // Open a gap for an insert, or close one for a delete
  always_ff @(posedge clk) begin
    if (ctrl.ins_shift && !lt) begin
      key <= left_lt ? q : left_key;
    end else if (ctrl.del_shift && !lt) begin
      key <= right_key;
    end
  end

  // Flag the boundary cell: first greater for next, last smaller for prev
  assign hit = (ctrl.sel_next && gt && !left_gt) || (ctrl.sel_prev && lt && !right_lt);
  assign hit_value = hit ? key : '0;

endmodule

// File: rtl/ordered_key_set_core.sv
// Top level of the ordered key set: a sorted chain of key cells and its sequencer.
//
//  channel | dir | tdata               | tuser        | tlast
//  s_*     | in  | [31:0] key          | [2:0] func   | -
//  m_*     | out | [31:0] value        | [1:0] status | -
//
// A request runs in a compare step and an update step: on the accept edge every
// cell compares its key with the request key, and in the update step the chain
// shifts and the result is loaded into the output register. The update waits
// while that register still holds an untaken result; a new request is accepted
// whenever no update is pending. Reset clears the key count and the handshake;
// cell contents are not cleared, since only cells below the count are ever read.
`include "ordered_key_set_core_macros.svh"

module ordered_key_set_core
  import okc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [KEY_W-1:0]  s_tdata,   // [31:0] key
  input  logic [FUNC_W-1:0] s_tuser,   // [2:0] func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [KEY_W-1:0]  m_tdata,   // [31:0] value
  output logic [STAT_W-1:0] m_tuser    // [1:0] status
);

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_UPD  = 1'b1;

  logic                    phase;
  logic [CNT_W-1:0]        count;
  logic [FUNC_W-1:0]       req_func;
  logic signed [KEY_W-1:0] req_key;

  logic s_xfer;
  logic upd_fire;
  logic present;
  logic full;
  logic ins_ok;
  logic del_ok;
  logic any_hit;
  cell_ctrl_t ctrl;

  logic                    lt_v  [CAPACITY];
  logic                    gt_v  [CAPACITY];
  logic                    eq_v  [CAPACITY];
  logic signed [KEY_W-1:0] key_v [CAPACITY];
  logic [CAPACITY-1:0]     eq_bits;
  logic [CAPACITY-1:0]     hit_bits;
  logic [KEY_W-1:0]        hval_v [CAPACITY];
  logic [KEY_W-1:0]        found;
  logic [STAT_W-1:0]       status_next;
  logic [KEY_W-1:0]        value_next;

  assign s_tready = (phase == PH_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign upd_fire = (phase == PH_UPD) && (!m_tvalid || m_tready);

  // Sequence the compare and update steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      unique case (phase)
        PH_IDLE: if (s_xfer) phase <= PH_UPD;
        PH_UPD:  if (upd_fire) phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // Hold the request for the update step
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      req_func <= s_tuser;
      req_key  <= s_tdata;
    end
  end

  assign present = |eq_bits;
  assign full    = (count == CNT_W'(CAPACITY));
  assign ins_ok  = (req_func == FN_INSERT) && !present && !full;
  assign del_ok  = (req_func == FN_DELETE) && present;

  assign ctrl.ins_shift = upd_fire && ins_ok;
  assign ctrl.del_shift = upd_fire && del_ok;
  assign ctrl.sel_next  = (req_func == FN_NEXT);
  assign ctrl.sel_prev  = (req_func == FN_PREV);

  // Build the chain of cells and wire each to its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    occ;
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;
    logic                    left_lt;
    logic                    left_gt;
    logic                    right_lt;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_key = key_v[i];
      assign left_lt  = 1'b1;
      assign left_gt  = 1'b0;
    end else begin : g_mid_l
      assign left_key = key_v[i-1];
      assign left_lt  = lt_v[i-1];
      assign left_gt  = gt_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = key_v[i];
      assign right_lt  = 1'b0;
    end else begin : g_mid_r
      assign right_key = key_v[i+1];
      assign right_lt  = lt_v[i+1];
    end

    okc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_en  (s_xfer),
      .probe     (s_tdata),
      .occ       (occ),
      .ctrl      (ctrl),
      .q         (req_key),
      .left_key  (left_key),
      .right_key (right_key),
      .left_lt   (left_lt),
      .left_gt   (left_gt),
      .right_lt  (right_lt),
      .lt        (lt_v[i]),
      .gt        (gt_v[i]),
      .eq        (eq_v[i]),
      .key       (key_v[i]),
      .hit       (hit_bits[i]),
      .hit_value (hval_v[i])
    );

    assign eq_bits[i] = eq_v[i];
  end

  // Merge the single boundary key, one output bit at a time
  always_comb begin
    for (int b = 0; b < KEY_W; b++) begin
      found[b] = 1'b0;
      for (int c = 0; c < CAPACITY; c++) begin
        found[b] = found[b] | hval_v[c][b];
      end
    end
  end

  assign any_hit = |hit_bits;

  // Form the result for the held request
  always_comb begin
    status_next = ST_NONE;
    value_next  = '0;
    unique case (req_func)
      FN_INSERT: status_next = (present || !full) ? ST_OK : ST_FULL;
      FN_DELETE: status_next = present ? ST_OK : ST_NONE;
      FN_EXISTS: status_next = present ? ST_OK : ST_NONE;
      FN_NEXT, FN_PREV: begin
        status_next = any_hit ? ST_OK : ST_NONE;
        value_next  = found;
      end
      default: status_next = ST_NONE;
    endcase
  end

  // Track the number of stored keys
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.ins_shift) begin
      count <= count + CNT_W'(1);
    end else if (ctrl.del_shift) begin
      count <= count - CNT_W'(1);
    end
  end

  // Drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      m_tdata <= value_next;
      m_tuser <= status_next;
    end
  end

  // Checks on the chain and the sequencer
  `OKC_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY))
  `OKC_ASSERT_NEXT(a_count_hold, !upd_fire, $stable(count))
  `OKC_ASSERT(a_hit_single, $onehot0(hit_bits))
  `OKC_ASSERT(a_full_status, !(m_tvalid && m_tuser == ST_FULL) || full)
  `OKC_ASSERT(a_result_after_update, !$rose(m_tvalid) || $past(phase == PH_UPD))

endmodule
